[design/kmio_pkg.sv]
// shared types, codes and constants for the key matrix i/o ports block
package kmio_pkg;

  localparam logic       OP_READ  = 1'b0;
  localparam logic       OP_WRITE = 1'b1;

  localparam logic [1:0] PORT_A   = 2'd0;
  localparam logic [1:0] PORT_B   = 2'd1;
  localparam logic [1:0] PORT_C   = 2'd2;
  localparam logic [1:0] PORT_NONE = 2'd3;

  // joystick bit positions
  localparam int JOY_UP    = 0;
  localparam int JOY_DOWN  = 1;
  localparam int JOY_LEFT  = 2;
  localparam int JOY_RIGHT = 3;
  localparam int JOY_TRIG1 = 4;
  localparam int JOY_TRIG2 = 5;

  // key bit positions
  localparam int KEY_DIGITS = 10;
  localparam int KEY_CLEAR  = 10;
  localparam int KEY_ENTER  = 11;
  localparam int KEY_PAUSE  = 12;

  localparam logic [7:0] SCAN_RESET    = 8'hff;
  localparam logic [7:0] CONTROL_RESET = 8'h00;
  localparam logic [7:0] IDLE_BYTE     = 8'hff;
  localparam logic [7:0] BANK_MASK     = 8'h60;
  localparam logic [7:0] SOUND_MASK    = 8'h08;
  localparam logic [7:0] C_READ_MASK   = 8'h78;
  localparam logic [7:0] C_READ_FIXED  = 8'h82;

  typedef struct packed {
    logic        op;
    logic [1:0]  port;
    logic [7:0]  write_data;
    logic [12:0] key_levels;
    logic [5:0]  joy_player1;
    logic [5:0]  joy_player2;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       bank_notify;
    logic       sound_notify;
    logic [7:0] port_c_level;
  } out_item_t;

endpackage

[design/key_matrix_io_ports_top.sv]
// top level of the key matrix i/o ports block
//
// Each input transfer is one port access (read or write of port a, b or c)
// with the current key and joystick levels; each yields exactly one result
// transfer with the byte read, the bank and sound notify bits and the port c
// level after the access.
// Both channels use valid/ready. An accepted item is held in the input
// register, is decoded against the port latches and lands in the result
// register, from which the result is offered. Throughput is one access per
// cycle unless the receiver stalls: the latches update as an item moves
// into the result register, so the next item sees them at once.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready drops only while both are full and out_ready is low.
// Synchronous reset sets scan_select to all ones and the control latch to
// zero, and empties both registers.
module key_matrix_io_ports_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kmio_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kmio_pkg::out_item_t out_data
);
  import kmio_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t result;
  logic      advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  kmio_access u_access (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (s1_item_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_item_r <= in_data;
    if (advance) out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // both stages drain whenever the receiver takes
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  a_bank_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bank_notify) |-> (out_data.read_data == IDLE_BYTE))
    else $error("bank notify on a read");

  a_sound_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.sound_notify) |-> (out_data.read_data == IDLE_BYTE))
    else $error("sound notify on a read");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");

endmodule

[design/kmio_matrix.sv]
// port b return lines of the keypad and joystick matrix, active low
module kmio_matrix (
  input  logic [7:0]  scan_select,
  input  logic [12:0] key_levels,
  input  logic [5:0]  joy_player1,
  input  logic [5:0]  joy_player2,
  output logic [7:0]  matrix_data
);
  import kmio_pkg::*;

  logic       row0;
  logic       row1;
  logic [5:0] joy_hit;
  logic       even_hit;
  logic       odd_hit;

  assign row0 = ~scan_select[0];
  assign row1 = ~scan_select[1];

  assign joy_hit[0] = (row0 & joy_player1[JOY_LEFT])  | (row1 & joy_player1[JOY_DOWN]);
  assign joy_hit[1] = (row0 & joy_player1[JOY_UP])    | (row1 & joy_player1[JOY_RIGHT]);
  assign joy_hit[2] = (row0 & joy_player1[JOY_TRIG1]) | (row1 & joy_player1[JOY_TRIG2]);
  assign joy_hit[3] = (row0 & joy_player2[JOY_LEFT])  | (row1 & joy_player2[JOY_DOWN]);
  assign joy_hit[4] = (row0 & joy_player2[JOY_UP])    | (row1 & joy_player2[JOY_RIGHT]);
  assign joy_hit[5] = (row0 & joy_player2[JOY_TRIG1]) | (row1 & joy_player2[JOY_TRIG2]);

  // digit pairs on scan lines 2..6, clear and enter on scan line 7
  always_comb begin
    even_hit = ~scan_select[7] & key_levels[KEY_CLEAR];
    odd_hit  = ~scan_select[7] & key_levels[KEY_ENTER];
    for (int k = 0; k < KEY_DIGITS / 2; k++) begin
      even_hit = even_hit | (~scan_select[k + 2] & key_levels[2 * k]);
      odd_hit  = odd_hit  | (~scan_select[k + 2] & key_levels[2 * k + 1]);
    end
  end

  assign matrix_data = ~{odd_hit, even_hit, joy_hit};

endmodule

[design/kmio_access.sv]
// port latches and access decode for one transfer
module kmio_access (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  kmio_pkg::in_item_t  item,
  output kmio_pkg::out_item_t result
);
  import kmio_pkg::*;

  logic [7:0] scan_select_r;
  logic [7:0] scan_select_nxt;
  logic [7:0] control_port_r;
  logic [7:0] control_port_nxt;
  logic [7:0] matrix_data;
  logic [7:0] c_read;

  kmio_matrix u_matrix (
    .scan_select (scan_select_r),
    .key_levels  (item.key_levels),
    .joy_player1 (item.joy_player1),
    .joy_player2 (item.joy_player2),
    .matrix_data (matrix_data)
  );

  assign c_read = (control_port_r & C_READ_MASK) | C_READ_FIXED
                | {7'd0, ~item.key_levels[KEY_PAUSE]};

  always_comb begin
    scan_select_nxt     = scan_select_r;
    control_port_nxt    = control_port_r;
    result.read_data    = IDLE_BYTE;
    result.bank_notify  = 1'b0;
    result.sound_notify = 1'b0;
    if (item.op == OP_WRITE) begin
      unique case (item.port)
        PORT_A: scan_select_nxt = item.write_data;
        PORT_C: begin
          result.bank_notify  = (item.write_data & BANK_MASK) != (control_port_r & BANK_MASK);
          result.sound_notify = (item.write_data & SOUND_MASK) != (control_port_r & SOUND_MASK);
          control_port_nxt    = item.write_data;
        end
        default: ;
      endcase
    end else begin
      unique case (item.port)
        PORT_A:  result.read_data = scan_select_r;
        PORT_B:  result.read_data = matrix_data;
        PORT_C:  result.read_data = c_read;
        default: result.read_data = IDLE_BYTE;
      endcase
    end
    result.port_c_level = control_port_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_select_r  <= SCAN_RESET;
      control_port_r <= CONTROL_RESET;
    end else if (step) begin
      scan_select_r  <= scan_select_nxt;
      control_port_r <= control_port_nxt;
    end
  end

endmodule

[test/tb_key_matrix_io_ports_top.sv]
// testbench for the key matrix i/o ports block: random and directed port accesses
`timescale 1ns / 100ps

module tb_key_matrix_io_ports_top;
  import kmio_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  access_queue[$];
  out_item_t expected_results[$];

  // latch copies for prediction
  logic [7:0] scan_latch = SCAN_RESET;
  logic [7:0] control_latch = CONTROL_RESET;

  int failures = 0;
  int accesses_sent = 0;
  int results_seen = 0;
  int in_wait = 0;
  int out_wait = 0;

  key_matrix_io_ports_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // stretches with no idling every few hundred transfers
  function automatic int draw_wait(input int n);
    return ((n % 300) < 60) ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic out_item_t predict_access(input in_item_t a);
    out_item_t r;
    r.read_data    = IDLE_BYTE;
    r.bank_notify  = 1'b0;
    r.sound_notify = 1'b0;
    if (a.op == OP_WRITE) begin
      if (a.port == PORT_A) begin
        scan_latch = a.write_data;
      end else if (a.port == PORT_C) begin
        r.bank_notify  = ((a.write_data & BANK_MASK) != (control_latch & BANK_MASK));
        r.sound_notify = ((a.write_data & SOUND_MASK) != (control_latch & SOUND_MASK));
        control_latch  = a.write_data;
      end
    end else begin
      if (a.port == PORT_A) begin
        r.read_data = scan_latch;
      end else if (a.port == PORT_B) begin
        // active-low return lines
        if (!scan_latch[0]) begin
          if (a.joy_player1[JOY_LEFT])  r.read_data[0] = 1'b0;
          if (a.joy_player1[JOY_UP])    r.read_data[1] = 1'b0;
          if (a.joy_player1[JOY_TRIG1]) r.read_data[2] = 1'b0;
          if (a.joy_player2[JOY_LEFT])  r.read_data[3] = 1'b0;
          if (a.joy_player2[JOY_UP])    r.read_data[4] = 1'b0;
          if (a.joy_player2[JOY_TRIG1]) r.read_data[5] = 1'b0;
        end
        if (!scan_latch[1]) begin
          if (a.joy_player1[JOY_DOWN])  r.read_data[0] = 1'b0;
          if (a.joy_player1[JOY_RIGHT]) r.read_data[1] = 1'b0;
          if (a.joy_player1[JOY_TRIG2]) r.read_data[2] = 1'b0;
          if (a.joy_player2[JOY_DOWN])  r.read_data[3] = 1'b0;
          if (a.joy_player2[JOY_RIGHT]) r.read_data[4] = 1'b0;
          if (a.joy_player2[JOY_TRIG2]) r.read_data[5] = 1'b0;
        end
        for (int k = 0; k < KEY_DIGITS / 2; k++) begin
          if (!scan_latch[2 + k]) begin
            if (a.key_levels[2 * k])     r.read_data[6] = 1'b0;
            if (a.key_levels[2 * k + 1]) r.read_data[7] = 1'b0;
          end
        end
        if (!scan_latch[7]) begin
          if (a.key_levels[KEY_CLEAR]) r.read_data[6] = 1'b0;
          if (a.key_levels[KEY_ENTER]) r.read_data[7] = 1'b0;
        end
      end else if (a.port == PORT_C) begin
        r.read_data = (control_latch & C_READ_MASK) | C_READ_FIXED
                      | {7'b0, ~a.key_levels[KEY_PAUSE]};
      end
    end
    r.port_c_level = control_latch;
    return r;
  endfunction

  function automatic in_item_t make_access(input logic op, input logic [1:0] port,
                                           input logic [7:0] data, input logic [12:0] keys,
                                           input logic [5:0] j1, input logic [5:0] j2);
    in_item_t a;
    a.op = op;
    a.port = port;
    a.write_data = data;
    a.key_levels = keys;
    a.joy_player1 = j1;
    a.joy_player2 = j2;
    return a;
  endfunction

  function automatic in_item_t random_access();
    in_item_t a;
    int sel;
    // sparse levels half the time so single keys show through the matrix
    if ($urandom_range(0, 1)) begin
      a.key_levels  = 13'($urandom_range(0, 8191));
      a.joy_player1 = 6'($urandom_range(0, 63));
      a.joy_player2 = 6'($urandom_range(0, 63));
    end else begin
      a.key_levels  = $urandom_range(0, 3) == 0 ? 13'd0 : 13'd1 << $urandom_range(0, 12);
      a.joy_player1 = $urandom_range(0, 3) == 0 ? 6'd0 : 6'd1 << $urandom_range(0, 5);
      a.joy_player2 = $urandom_range(0, 3) == 0 ? 6'd0 : 6'd1 << $urandom_range(0, 5);
    end
    a.write_data = 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      a.op = OP_WRITE;
      a.port = PORT_A;
      if ($urandom_range(0, 1))
        a.write_data = ~(8'd1 << $urandom_range(0, 7)) & ~(8'd1 << $urandom_range(0, 7));
    end else if (sel < 50) begin
      a.op = OP_READ;
      a.port = PORT_B;
    end else if (sel < 65) begin
      a.op = OP_WRITE;
      a.port = PORT_C;
    end else if (sel < 75) begin
      a.op = OP_READ;
      a.port = PORT_C;
    end else if (sel < 82) begin
      a.op = OP_READ;
      a.port = PORT_A;
    end else if (sel < 88) begin
      a.op = OP_WRITE;
      a.port = PORT_B;
    end else begin
      a.op = 1'($urandom_range(0, 1));
      a.port = PORT_NONE;
    end
    return a;
  endfunction

  // driver: one transfer per item, random wait before each
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait = draw_wait(0);
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_access(in_data));
        accesses_sent++;
        in_wait = draw_wait(accesses_sent);
      end
      if (!in_valid || in_ready) begin
        if (in_wait == 0 && access_queue.size() > 0) begin
          in_data  <= access_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (in_wait > 0) in_wait--;
        end
      end
    end
  end

  // monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait = draw_wait(0);
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no access pending: %h", out_data);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, out_data.read_data);
            failures++;
          end
          if (out_data.bank_notify !== want.bank_notify) begin
            $error("bank_notify: expected %b, got %b", want.bank_notify,
                   out_data.bank_notify);
            failures++;
          end
          if (out_data.sound_notify !== want.sound_notify) begin
            $error("sound_notify: expected %b, got %b", want.sound_notify,
                   out_data.sound_notify);
            failures++;
          end
          if (out_data.port_c_level !== want.port_c_level) begin
            $error("port_c_level: expected %h, got %h", want.port_c_level,
                   out_data.port_c_level);
            failures++;
          end
        end
        results_seen++;
        out_wait = draw_wait(results_seen);
      end
      if (out_wait > 0) begin
        out_ready <= 1'b0;
        out_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [12:0] all_keys;
    int          total_items;
    all_keys = '1;

    // latches straight after reset
    access_queue.push_back(make_access(OP_READ, PORT_A, 8'h00, '0, '0, '0));
    access_queue.push_back(make_access(OP_READ, PORT_C, 8'h00, '0, '0, '0));
    access_queue.push_back(make_access(OP_READ, PORT_B, 8'h00, all_keys, '1, '1));
    // unmapped port and port b writes leave the latches alone
    access_queue.push_back(make_access(OP_READ, PORT_NONE, 8'h00, all_keys, '1, '1));
    access_queue.push_back(make_access(OP_WRITE, PORT_NONE, 8'h00, '0, '0, '0));
    access_queue.push_back(make_access(OP_WRITE, PORT_B, 8'h00, '0, '0, '0));
    // bank change, sound change, no change, everything, back to zero
    access_queue.push_back(make_access(OP_WRITE, PORT_C, 8'h60, '0, '0, '0));
    access_queue.push_back(make_access(OP_WRITE, PORT_C, 8'h68, '0, '0, '0));
    access_queue.push_back(make_access(OP_WRITE, PORT_C, 8'h68, '0, '0, '0));
    access_queue.push_back(make_access(OP_WRITE, PORT_C, 8'hff, '0, '0, '0));
    access_queue.push_back(make_access(OP_READ, PORT_C, 8'h00, all_keys, '0, '0));
    access_queue.push_back(make_access(OP_WRITE, PORT_C, 8'h00, '0, '0, '0));
    // walking zero over the scan lines
    for (int k = 0; k < 8; k++) begin
      access_queue.push_back(make_access(OP_WRITE, PORT_A, ~(8'd1 << k), '0, '0, '0));
      access_queue.push_back(make_access(OP_READ, PORT_B, 8'h00,
                                         13'($urandom_range(0, 8191)),
                                         6'($urandom_range(0, 63)),
                                         6'($urandom_range(0, 63))));
    end
    access_queue.push_back(make_access(OP_WRITE, PORT_A, 8'h00, '0, '0, '0));
    access_queue.push_back(make_access(OP_READ, PORT_B, 8'h00, all_keys, '1, '1));

    for (int n = 0; n < 1500; n++) access_queue.push_back(random_access());
    total_items = access_queue.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (results_seen < total_items)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
design/kmio_pkg.sv
design/kmio_matrix.sv
design/kmio_access.sv
design/key_matrix_io_ports_top.sv
test/tb_key_matrix_io_ports_top.sv
